// ----- rtl/core/gwm_pkg.sv -----
// Shared types, constants and helpers for the glob wildcard matcher.
package gwm_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_END    = 2'd3
    } cmd_t;

    localparam logic [7:0] STAR_CHAR = 8'h2A;
    localparam logic [7:0] ANY_CHAR  = 8'h3F;
    localparam logic [7:0] LOWER_A   = 8'h61;
    localparam logic [7:0] LOWER_Z   = 8'h7A;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    // ASCII upper-case fold, letters only
    function automatic logic [7:0] fold(input logic [7:0] c, input logic icase);
        logic [7:0] r;
        r = c;
        if (icase && (c >= LOWER_A) && (c <= LOWER_Z)) begin
            r = c - CASE_BIT;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/gwm_closure.sv -----
// Segmented prefix-OR that closes an active-position vector over star skips.
module gwm_closure #(
    parameter int N = 32
) (
    input  logic [N:0]   raw_i,
    input  logic [N-1:0] star_i,
    output logic [N:0]   closed_o
);
    localparam int W      = N + 1;
    localparam int LEVELS = $clog2(W);

    // g: reached, p: position j can be reached from j-1 through a star
    logic [W-1:0] g [LEVELS+1];
    logic [W-1:0] p [LEVELS+1];

    assign g[0] = raw_i;
    assign p[0] = {star_i, 1'b0};

    for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
        localparam int D = 1 << l;
        assign g[l+1] = g[l] | (p[l] & (g[l] << D));
        assign p[l+1] = p[l] & (p[l] << D);
    end

    assign closed_o = g[LEVELS];

endmodule

// ----- rtl/core/glob_wildcard_matcher.sv -----
// Top level of the glob wildcard matcher: pattern store, active-position vector, result register.
//
//  channel | dir | handshake            | payload
//  s_      | in  | s_tvalid / s_tready  | s_tuser command, s_tdata char_value
//  m_      | out | m_tvalid / m_tready  | m_tdata matched, pattern_overflow
//  cfg_    | in  | cfg_valid / cfg_ready| cfg_data ignore_case
//
//  One word per cycle sustained while the result is not stalled; the active-vector update for
//  one word is combinational in the update stage, two log-depth closure networks set its depth.
//  An end-of-text word passes the input register, then the result register, which drives m_tvalid.
//  Reset (aresetn low, synchronous) empties the pattern, clears overflow and case mode.
//  A stalled result blocks the update stage; the input register still takes one word.
module glob_wildcard_matcher #(
    parameter int MAX_PATTERN = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_value
    input  logic [1:0] s_tuser,   // [1:0] command
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] matched, [1] pattern_overflow, [7:2] zero
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);
    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // input register
    logic               in_valid_reg, in_valid_next;
    gwm_pkg::cmd_t      in_cmd_reg;
    logic [7:0]         in_char_reg;

    // matcher state
    logic [7:0]         pat_reg [MAX_PATTERN];
    logic [LW-1:0]      len_reg, len_next;
    logic               ovf_reg, ovf_next;
    logic [MAX_PATTERN:0] active_reg, active_next;
    logic               icase_reg;

    // result register
    logic               m_valid_reg, m_valid_next;
    logic               m_match_reg, m_ovf_reg;

    logic               advance;
    logic               room;
    logic               wr_en;
    logic [7:0]         fc;
    logic [MAX_PATTERN-1:0] star_vec, adv_vec, new_star, restart_star;
    logic [MAX_PATTERN:0]   step_raw, step_closed, restart_closed;
    logic                   match_bit;

    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign room      = (len_reg < LW'(MAX_PATTERN));
    assign wr_en     = advance && (in_cmd_reg == gwm_pkg::CMD_APPEND) && room;
    assign fc        = gwm_pkg::fold(in_char_reg, icase_reg);

    // per-position lanes
    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_lane
        logic in_pat;
        logic is_star;
        logic hit;
        assign in_pat  = (LW'(i) < len_reg);
        assign is_star = in_pat && (pat_reg[i] == gwm_pkg::STAR_CHAR);
        assign hit     = (pat_reg[i] == gwm_pkg::ANY_CHAR)
                      || (gwm_pkg::fold(pat_reg[i], icase_reg) == fc);
        assign star_vec[i] = is_star;
        assign adv_vec[i]  = in_pat && !is_star && hit && active_reg[i];
        assign new_star[i] = is_star || (room && (len_reg == LW'(i))
                                         && (in_char_reg == gwm_pkg::STAR_CHAR));
    end

    assign step_raw = {1'b0, active_reg[MAX_PATTERN-1:0] & star_vec} | {adv_vec, 1'b0};

    always_comb begin
        case (in_cmd_reg)
            gwm_pkg::CMD_CLEAR:  restart_star = '0;
            gwm_pkg::CMD_APPEND: restart_star = new_star;
            default:             restart_star = star_vec;
        endcase
    end

    gwm_closure #(.N(MAX_PATTERN)) u_step_closure (
        .raw_i    (step_raw),
        .star_i   (star_vec),
        .closed_o (step_closed)
    );

    gwm_closure #(.N(MAX_PATTERN)) u_restart_closure (
        .raw_i    ((MAX_PATTERN+1)'(1)),
        .star_i   (restart_star),
        .closed_o (restart_closed)
    );

    assign match_bit = !ovf_reg && active_reg[len_reg];

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        len_next    = len_reg;
        ovf_next    = ovf_reg;
        active_next = active_reg;
        if (advance) begin
            case (in_cmd_reg)
                gwm_pkg::CMD_CLEAR: begin
                    len_next    = '0;
                    ovf_next    = 1'b0;
                    active_next = restart_closed;
                end
                gwm_pkg::CMD_APPEND: begin
                    if (room) begin
                        len_next = len_reg + LW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    active_next = restart_closed;
                end
                gwm_pkg::CMD_TEXT: active_next = step_closed;
                default:           active_next = restart_closed;
            endcase
        end

        m_valid_next = m_valid_reg;
        if (advance && (in_cmd_reg == gwm_pkg::CMD_END)) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            active_reg   <= (MAX_PATTERN+1)'(1);
            icase_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            len_reg      <= len_next;
            ovf_reg      <= ovf_next;
            active_reg   <= active_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid) begin
                icase_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= gwm_pkg::cmd_t'(s_tuser);
            in_char_reg <= s_tdata;
        end
        if (wr_en) begin
            pat_reg[len_reg[IW-1:0]] <= in_char_reg;
        end
        if (advance && (in_cmd_reg == gwm_pkg::CMD_END)) begin
            m_match_reg <= match_bit;
            m_ovf_reg   <= ovf_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_ovf_reg, m_match_reg};

`ifndef SYNTH
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(MAX_PATTERN))
        else $error("pattern length beyond capacity");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (len_reg == LW'(MAX_PATTERN)))
        else $error("overflow flagged with room left");

    a_match_no_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("match reported with overflow");

    a_restart_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_cmd_reg != gwm_pkg::CMD_TEXT)) |=> active_reg[0])
        else $error("start position inactive after restart");

    a_result_only_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg && !(advance && (in_cmd_reg == gwm_pkg::CMD_END))) |=> !m_valid_reg)
        else $error("result word without end of text");
`endif

endmodule
